// File: hw/rtl/gyro_turn_detector_core_assert.svh
// Assertion macros used by the turn detector port checker.
// Clock aclk and active-low reset aresetn must be visible where these are used.
`ifndef GYRO_TURN_DETECTOR_CORE_ASSERT_SVH
`define GYRO_TURN_DETECTOR_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define GTD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define GTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define GTD_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/gtd_pkg.sv
// Shared types and constants of the gyro turn detector.
// No dependencies.
`timescale 1ns / 1ps

package gtd_pkg;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_SKIP   = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    // register indexes
    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_FORWARD   = 2'd1;
    localparam logic [1:0] REG_BACKWARD  = 2'd2;
    localparam logic [1:0] REG_LONG      = 2'd3;

    localparam logic [6:0] THRESHOLD_RST = 7'd4;
    localparam logic [3:0] FORWARD_RST   = 4'd1;
    localparam logic [3:0] BACKWARD_RST  = 4'd2;
    localparam logic [3:0] LONG_RST      = 4'd3;

    localparam int IN_W  = 48;
    localparam int OUT_W = 48;

    localparam logic [15:0] CLAMP_STEPS = 16'd2;

    typedef struct packed {
        logic [6:0] threshold;
        logic [3:0] forward_code;
        logic [3:0] backward_code;
        logic [3:0] long_distance_code;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  command;
        logic [15:0] steps_to_go;
        logic [15:0] skip_value;
    } item_t;

    typedef struct packed {
        logic [15:0] steps_out;
        logic [15:0] saved_steps;
        logic [3:0]  saved_command;
        logic        captured;
        logic        turn_detected;
        logic        over_threshold;
        logic        skipped;
        logic [7:0]  mean;
    } result_t;

endpackage

// File: hw/rtl/gtd_cell.sv
// One window cell: holds a sample and passes it on when the window shifts.
// No dependencies.
`timescale 1ns / 1ps

module gtd_cell (
    input  logic              aclk,
    input  logic              shift_en,
    input  logic signed [7:0] d,
    output logic signed [7:0] q
);

    logic signed [7:0] q_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

// File: hw/rtl/gtd_window.sv
// Sample window as a chain of cells, with fill tracking and the running sum.
// Uses gtd_cell.
`timescale 1ns / 1ps

module gtd_window #(
    parameter int WINDOW = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            shift_en,
    input  logic signed [7:0]               sample,
    output logic signed [8+$clog2(WINDOW)-1:0] sum
);

    localparam int SUM_W = 8 + $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW);

    logic signed [7:0]       cell_q [WINDOW];
    logic signed [7:0]       oldest;
    logic [CNT_W-1:0]        fill_reg;
    logic                    full_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;

    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        if (i == 0) begin : g_head
            gtd_cell u_cell (.aclk(aclk), .shift_en(shift_en), .d(sample), .q(cell_q[i]));
        end else begin : g_body
            gtd_cell u_cell (.aclk(aclk), .shift_en(shift_en), .d(cell_q[i-1]), .q(cell_q[i]));
        end
    end

    // until the window has filled once, the dropped entry is a reset zero
    assign oldest   = full_reg ? cell_q[WINDOW-1] : 8'sd0;
    assign sum_next = sum_reg - SUM_W'(oldest) + SUM_W'(sample);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            full_reg <= 1'b0;
            sum_reg  <= '0;
        end else if (shift_en) begin
            sum_reg <= sum_next;
            if (!full_reg) begin
                if (fill_reg == CNT_W'(WINDOW - 1)) begin
                    full_reg <= 1'b1;
                end else begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    assign sum = sum_reg;

endmodule

// File: hw/rtl/gtd_detect.sv
// Mean by reciprocal multiply, threshold test, skip count and turn latch.
// Uses gtd_pkg; fed by the window sum.
`timescale 1ns / 1ps

module gtd_detect #(
    parameter int WINDOW = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  gtd_pkg::cfg_t                      cfg,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  gtd_pkg::item_t                     in_item,
    input  logic signed [8+$clog2(WINDOW)-1:0] sum,
    output logic                               m_valid,
    input  logic                               m_ready,
    output gtd_pkg::result_t                   m_result
);

    import gtd_pkg::*;

    localparam int SUM_W  = 8 + $clog2(WINDOW);
    localparam int SH     = SUM_W + $clog2(WINDOW);
    localparam int M_W    = SUM_W + 2;
    localparam int PROD_W = SUM_W + M_W;
    localparam longint unsigned RECIP = ((64'd1 << SH) + WINDOW - 1) / WINDOW;

    logic [M_W-1:0]    recip;
    logic [SUM_W-1:0]  mag;

    logic              s2_valid_reg;
    item_t             s2_item_reg;
    logic              s2_neg_reg;
    logic [PROD_W-1:0] s2_prod_reg;

    logic              m_valid_reg, m_valid_next;
    result_t           res_reg, res_next;
    logic [15:0]       skip_reg, skip_next;
    logic              latch_reg, latch_next;
    logic [3:0]        held_cmd_reg, held_cmd_next;
    logic [15:0]       held_steps_reg, held_steps_next;

    logic              adv;
    logic [7:0]        quot;
    logic [7:0]        mean_val;
    logic              over;
    logic              straight;

    assign recip = M_W'(RECIP);
    assign mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

    assign adv      = s2_valid_reg && (!m_valid_reg || m_ready);
    assign in_ready = !s2_valid_reg || !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s2_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            s2_item_reg <= in_item;
            s2_neg_reg  <= sum[SUM_W-1];
            s2_prod_reg <= PROD_W'(mag) * PROD_W'(recip);
        end
    end

    // quotient magnitude never exceeds 128
    assign quot     = s2_prod_reg[SH +: 8];
    assign mean_val = s2_neg_reg ? (~quot + 8'd1) : quot;
    assign over     = quot > {1'b0, cfg.threshold};
    assign straight = (s2_item_reg.command == cfg.forward_code)
                   || (s2_item_reg.command == cfg.backward_code)
                   || (s2_item_reg.command == cfg.long_distance_code);

    always_comb begin
        skip_next       = skip_reg;
        latch_next      = latch_reg;
        held_cmd_next   = held_cmd_reg;
        held_steps_next = held_steps_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        if (adv) begin
            case (s2_item_reg.kind)
                KIND_SAMPLE: begin
                    m_valid_next            = 1'b1;
                    res_next.mean           = mean_val;
                    res_next.skipped        = 1'b0;
                    res_next.over_threshold = 1'b0;
                    res_next.captured       = 1'b0;
                    res_next.steps_out      = s2_item_reg.steps_to_go;
                    if (skip_reg != 16'd0) begin
                        skip_next        = skip_reg - 16'd1;
                        res_next.skipped = 1'b1;
                    end else begin
                        res_next.over_threshold = over;
                        if (over && straight) begin
                            if (!latch_reg) begin
                                held_cmd_next     = s2_item_reg.command;
                                held_steps_next   = s2_item_reg.steps_to_go;
                                res_next.captured = 1'b1;
                                if (s2_item_reg.steps_to_go > CLAMP_STEPS) begin
                                    res_next.steps_out = CLAMP_STEPS;
                                end
                            end
                            latch_next = 1'b1;
                        end
                    end
                    res_next.turn_detected = latch_next;
                    res_next.saved_command = held_cmd_next;
                    res_next.saved_steps   = held_steps_next;
                end
                KIND_SKIP: begin
                    skip_next = s2_item_reg.skip_value;
                end
                KIND_CLEAR: begin
                    latch_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skip_reg       <= '0;
            latch_reg      <= 1'b0;
            held_cmd_reg   <= '0;
            held_steps_reg <= '0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skip_reg       <= skip_next;
            latch_reg      <= latch_next;
            held_cmd_reg   <= held_cmd_next;
            held_steps_reg <= held_steps_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = res_reg;

endmodule

// File: hw/rtl/gyro_turn_detector_core.sv
// Gyro turn detector: sample window, running mean and turn latch.
// Uses gtd_pkg, gtd_window, gtd_detect.
`timescale 1ns / 1ps
//
// Input stream (s_*): one transaction per item. s_tuser carries the kind
// (gyro sample, load skip count, clear turn latch); s_tdata the sample,
// command, steps left and skip value. Only gyro samples produce a result
// transaction on m_*; the other kinds update state silently.
// Registers sit behind the APB port at 0x0 threshold, 0x4 forward code,
// 0x8 backward code, 0xC long-distance code; write them only while idle.
// Throughput: one item per cycle while m_tready does not stall the output. A
// result passes through the window sum (updated at the accepting edge), the
// reciprocal multiply register, then detect into the output register.
// Reset: the window reads as all zero until it has filled once (a fill
// counter tracks this), so items are taken right after reset, no sweep.
// Stall: with m_tready low the pipeline keeps taking items until its three
// stages are full, then drops s_tready; nothing is lost or repeated.
//
module gyro_turn_detector_core #(
    parameter int WINDOW = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // sample[7:0], command[11:8], steps_to_go[27:12], skip_value[43:28], zero[47:44]
    input  logic [gtd_pkg::IN_W-1:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]               s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // mean[7:0], skipped[8], over_threshold[9], turn_detected[10], captured[11],
    // saved_command[15:12], saved_steps[31:16], steps_out[47:32]
    output logic [gtd_pkg::OUT_W-1:0] m_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    import gtd_pkg::*;

    localparam int SUM_W = 8 + $clog2(WINDOW);

    cfg_t                    cfg_reg;
    logic                    cfg_wr;
    logic [1:0]              reg_idx;

    item_t                   in_item;
    logic                    accept;
    logic                    s1_valid_reg;
    item_t                   s1_item_reg;
    logic                    det_ready;
    logic signed [SUM_W-1:0] sum;
    result_t                 result;

    // config port
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold          <= THRESHOLD_RST;
            cfg_reg.forward_code       <= FORWARD_RST;
            cfg_reg.backward_code      <= BACKWARD_RST;
            cfg_reg.long_distance_code <= LONG_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_THRESHOLD: cfg_reg.threshold          <= pwdata[6:0];
                REG_FORWARD:   cfg_reg.forward_code       <= pwdata[3:0];
                REG_BACKWARD:  cfg_reg.backward_code      <= pwdata[3:0];
                REG_LONG:      cfg_reg.long_distance_code <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_THRESHOLD: prdata = 32'(cfg_reg.threshold);
            REG_FORWARD:   prdata = 32'(cfg_reg.forward_code);
            REG_BACKWARD:  prdata = 32'(cfg_reg.backward_code);
            REG_LONG:      prdata = 32'(cfg_reg.long_distance_code);
            default:       prdata = 32'd0;
        endcase
    end

    // input stage: the window sum is updated in the same cycle
    assign in_item.kind        = kind_t'(s_tuser);
    assign in_item.command     = s_tdata[11:8];
    assign in_item.steps_to_go = s_tdata[27:12];
    assign in_item.skip_value  = s_tdata[43:28];

    assign s_tready = !s1_valid_reg || det_ready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            s1_item_reg <= in_item;
        end
    end

    gtd_window #(.WINDOW(WINDOW)) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (accept && (in_item.kind == KIND_SAMPLE)),
        .sample   ($signed(s_tdata[7:0])),
        .sum      (sum)
    );

    gtd_detect #(.WINDOW(WINDOW)) u_detect (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s1_valid_reg),
        .in_ready (det_ready),
        .in_item  (s1_item_reg),
        .sum      (sum),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    assign m_tdata = result;

endmodule

// File: hw/rtl/gtd_port_checker.sv
// Port-level checks on the turn detector's result stream, bound to the top.
// Uses gtd_pkg and gyro_turn_detector_core_assert.svh.
`timescale 1ns / 1ps
`include "gyro_turn_detector_core_assert.svh"

module gtd_port_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [gtd_pkg::OUT_W-1:0] m_tdata
);

    import gtd_pkg::*;

    // a stalled result holds
    `GTD_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    // a capture always leaves the latch set
    `GTD_ASSERT_IMPL(a_capture_latch, m_tvalid && m_tdata[11], m_tdata[10], "capture without turn latch")
    // a skipped sample never flags over-threshold or captures
    `GTD_ASSERT_IMPL(a_skip_quiet, m_tvalid && m_tdata[8], !m_tdata[9] && !m_tdata[11], "skipped sample detected")
    // captured steps are clamped
    `GTD_ASSERT_IMPL(a_capture_clamp, m_tvalid && m_tdata[11], m_tdata[47:32] <= CLAMP_STEPS, "captured steps not clamped")
    // no result straight out of reset
    `GTD_ASSERT_RST(a_reset_idle, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind gyro_turn_detector_core gtd_port_checker u_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
